// ----- rtl/core/bilinear_image_resize_defines.svh -----
// ----------------------------------------------------------------------------
// bilinear_image_resize_defines
// Assertion macros shared by the bilinear image resize RTL.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_RESIZE_DEFINES_SVH
`define BILINEAR_IMAGE_RESIZE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off while arst_n is low
`define BIR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bilinear_image_resize: assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define BIR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bilinear_image_resize: assertion failed");

`else

`define BIR_ASSERT_NOW(label, ante, cons)
`define BIR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/bir_pkg.sv -----
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types, constants and register codes of the bilinear image resize.
// ----------------------------------------------------------------------------
package bir_pkg;

	// default geometry of the sample store
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_CHANNELS   = 3;

	// field widths
	localparam int SIZE_W    = 9;
	localparam int STEP_W    = 24;
	localparam int SAMPLE_W  = 8;
	localparam int POS_W     = 8;
	localparam int CH_W      = 2;
	localparam int PIX_W     = 16;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 3;

	// item kinds
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH  = 3'd0,
		CFG_SRC_HEIGHT = 3'd1,
		CFG_DST_WIDTH  = 3'd2,
		CFG_DST_HEIGHT = 3'd3,
		CFG_X_STEP     = 3'd4,
		CFG_Y_STEP     = 3'd5
	} cfg_idx_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INDEX,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C,
		ST_RD_D,
		ST_HORZ,
		ST_VERT
	} bir_state_t;

	// which neighbor the sample store reads
	typedef enum logic [1:0] {
		RD_R0C0,
		RD_R0C1,
		RD_R1C0,
		RD_R1C1
	} rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    take_item;
		logic    calc_index;
		rd_sel_t rd_sel;
		logic    cap_sample;
		logic    calc_h0;
		logic    calc_h1;
		logic    load_out;
	} bir_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_request;
		logic req_err;
	} bir_status_t;

endpackage

// ----- rtl/core/bir_ram.sv -----
// ----------------------------------------------------------------------------
// bir_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one access per cycle, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- rtl/core/bir_ctrl.sv -----
// ----------------------------------------------------------------------------
// bir_ctrl
// Sequencer of the bilinear image resize: one item at a time, output register
// valid flag.
// ----------------------------------------------------------------------------
module bir_ctrl import bir_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  bir_status_t status,
	output bir_cmd_t    cmd
);

	bir_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rd_sel     = RD_R0C0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					if (status.is_request) begin
						state_d = ST_INDEX;
					end
				end
			end
			ST_INDEX: begin
				cmd.calc_index = 1'b1;
				state_d = status.req_err ? ST_VERT : ST_RD_A;
			end
			ST_RD_A: begin
				cmd.rd_sel = RD_R0C0;
				state_d = ST_RD_B;
			end
			ST_RD_B: begin
				cmd.rd_sel     = RD_R0C1;
				cmd.cap_sample = 1'b1;
				state_d = ST_RD_C;
			end
			ST_RD_C: begin
				cmd.rd_sel  = RD_R1C0;
				cmd.calc_h0 = 1'b1;
				state_d = ST_RD_D;
			end
			ST_RD_D: begin
				cmd.rd_sel     = RD_R1C1;
				cmd.cap_sample = 1'b1;
				state_d = ST_HORZ;
			end
			ST_HORZ: begin
				cmd.calc_h1 = 1'b1;
				state_d = ST_VERT;
			end
			ST_VERT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/bir_datapath.sv -----
// ----------------------------------------------------------------------------
// bir_datapath
// Configuration registers, sample store, neighbor indexing and the two
// blend steps of the bilinear image resize.
// ----------------------------------------------------------------------------
module bir_datapath import bir_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int CHANNELS   = DEF_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_data,
	input  logic                 kind,
	input  logic [SAMPLE_W-1:0]  sample_value,
	input  logic [POS_W-1:0]     pos_x,
	input  logic [POS_W-1:0]     pos_y,
	input  logic [CH_W-1:0]      channel_index,
	input  bir_cmd_t             cmd,
	output bir_status_t          status,
	output logic [PIX_W-1:0]     pixel_value,
	output logic                 range_error
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int DEPTH = CHANNELS * (2 ** (XW + YW));
	localparam int AW    = $clog2(DEPTH);

	// configuration registers
	logic [SIZE_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [STEP_W-1:0] x_step_q, y_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SIZE_W'(1);
			src_height_q <= SIZE_W'(1);
			dst_width_q  <= SIZE_W'(1);
			dst_height_q <= SIZE_W'(1);
			x_step_q     <= '0;
			y_step_q     <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SRC_WIDTH:  src_width_q  <= cfg_data[SIZE_W-1:0];
				CFG_SRC_HEIGHT: src_height_q <= cfg_data[SIZE_W-1:0];
				CFG_DST_WIDTH:  dst_width_q  <= cfg_data[SIZE_W-1:0];
				CFG_DST_HEIGHT: dst_height_q <= cfg_data[SIZE_W-1:0];
				CFG_X_STEP:     x_step_q     <= cfg_data;
				CFG_Y_STEP:     y_step_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective sizes, saturated to 1..max
	logic [SIZE_W-1:0] sw, sh, dw, dh;

	always_comb begin
		sw = (src_width_q == '0) ? SIZE_W'(1) :
			((32'(src_width_q) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : src_width_q);
		sh = (src_height_q == '0) ? SIZE_W'(1) :
			((32'(src_height_q) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : src_height_q);
		dw = (dst_width_q == '0) ? SIZE_W'(1) :
			((32'(dst_width_q) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : dst_width_q);
		dh = (dst_height_q == '0) ? SIZE_W'(1) :
			((32'(dst_height_q) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : dst_height_q);
	end

	// incoming item checks
	logic load_ok, req_bad, ch_ok;

	assign ch_ok   = (32'(channel_index) < CHANNELS);
	assign load_ok = ({1'b0, pos_x} < sw) && ({1'b0, pos_y} < sh) && ch_ok;
	assign req_bad = ({1'b0, pos_x} >= dw) || ({1'b0, pos_y} >= dh) || !ch_ok;

	// request capture
	logic [POS_W-1:0] req_x_q, req_y_q;
	logic [CH_W-1:0]  req_ch_q;
	logic             req_err_q;

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			req_x_q   <= pos_x;
			req_y_q   <= pos_y;
			req_ch_q  <= channel_index;
			req_err_q <= req_bad;
		end
	end

	assign status.is_request = (kind == KIND_REQUEST);
	assign status.req_err    = req_err_q;

	// neighbor indexes and fractions
	logic [31:0]         sx, sy;
	logic [15:0]         sx_int, sy_int;
	logic [SIZE_W-1:0]   col_last, row_last;
	logic [SIZE_W-1:0]   col0_d, col1_d, row0_d, row1_d;
	logic                col_edge, row_edge;

	assign sx       = {{(32-POS_W){1'b0}}, req_x_q} * {{(32-STEP_W){1'b0}}, x_step_q};
	assign sy       = {{(32-POS_W){1'b0}}, req_y_q} * {{(32-STEP_W){1'b0}}, y_step_q};
	assign sx_int   = sx[31:FRAC_W];
	assign sy_int   = sy[31:FRAC_W];
	assign col_last = sw - SIZE_W'(1);
	assign row_last = sh - SIZE_W'(1);
	assign col_edge = ({1'b0, req_x_q} == dw - SIZE_W'(1)) || (sw == SIZE_W'(1));
	assign row_edge = ({1'b0, req_y_q} == dh - SIZE_W'(1)) || (sh == SIZE_W'(1));

	always_comb begin
		col0_d = (sx_int > 16'(col_last)) ? col_last : sx_int[SIZE_W-1:0];
		col1_d = ((17'(sx_int) + 17'd1) > 17'(col_last)) ?
			col_last : (sx_int[SIZE_W-1:0] + SIZE_W'(1));
		row0_d = (sy_int > 16'(row_last)) ? row_last : sy_int[SIZE_W-1:0];
		row1_d = ((17'(sy_int) + 17'd1) > 17'(row_last)) ?
			row_last : (sy_int[SIZE_W-1:0] + SIZE_W'(1));
	end

	logic [SIZE_W-1:0] col0_q, col1_q, row0_q, row1_q;
	logic [FRAC_W-1:0] fx_q, fy_q;

	// edge column or row collapses to the last source sample with weight one
	always_ff @(posedge clk) begin
		if (cmd.calc_index) begin
			col0_q <= col_edge ? col_last : col0_d;
			col1_q <= col_edge ? col_last : col1_d;
			fx_q   <= col_edge ? '0 : sx[FRAC_W-1:0];
			row0_q <= row_edge ? row_last : row0_d;
			row1_q <= row_edge ? row_last : row1_d;
			fy_q   <= row_edge ? '0 : sy[FRAC_W-1:0];
		end
	end

	// sample store address: load on transfer, otherwise neighbor read
	logic [SIZE_W-1:0]   rd_col, rd_row;
	logic [AW-1:0]       mem_addr;
	logic                mem_we;
	logic [SAMPLE_W-1:0] mem_rdata;

	always_comb begin
		case (cmd.rd_sel)
			RD_R0C0: begin rd_row = row0_q; rd_col = col0_q; end
			RD_R0C1: begin rd_row = row0_q; rd_col = col1_q; end
			RD_R1C0: begin rd_row = row1_q; rd_col = col0_q; end
			default: begin rd_row = row1_q; rd_col = col1_q; end
		endcase
		if (cmd.take_item) begin
			mem_addr = AW'({channel_index, YW'(pos_y), XW'(pos_x)});
		end else begin
			mem_addr = AW'({req_ch_q, YW'(rd_row), XW'(rd_col)});
		end
	end

	assign mem_we = cmd.take_item && (kind == KIND_LOAD) && load_ok;

	bir_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(sample_value),
		.rdata(mem_rdata)
	);

	// horizontal blend: s0*2^16 + fx*(s1-s0), then drop 8 bits
	logic [SAMPLE_W-1:0]  samp_q;
	logic signed [8:0]    hdiff;
	logic signed [25:0]   hprod, hsum;
	logic [PIX_W-1:0]     h_blend;

	assign hdiff   = $signed({1'b0, mem_rdata}) - $signed({1'b0, samp_q});
	assign hprod   = $signed({1'b0, fx_q}) * hdiff;
	assign hsum    = $signed({2'b00, samp_q, 16'h0000}) + hprod;
	assign h_blend = hsum[23:8];

	logic [PIX_W-1:0] h0_q, h1_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_sample) begin
			samp_q <= mem_rdata;
		end
		if (cmd.calc_h0) begin
			h0_q <= h_blend;
		end
		if (cmd.calc_h1) begin
			h1_q <= h_blend;
		end
	end

	// vertical blend: h0*2^16 + fy*(h1-h0), then drop 16 bits
	logic signed [16:0] vdiff;
	logic signed [33:0] vprod, vsum;
	logic [PIX_W-1:0]   v_blend;

	assign vdiff   = $signed({1'b0, h1_q}) - $signed({1'b0, h0_q});
	assign vprod   = $signed({1'b0, fy_q}) * vdiff;
	assign vsum    = $signed({2'b00, h0_q, 16'h0000}) + vprod;
	assign v_blend = vsum[31:16];

	// output register
	logic [PIX_W-1:0] pixel_q;
	logic             err_out_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pixel_q   <= req_err_q ? '0 : v_blend;
			err_out_q <= req_err_q;
		end
	end

	assign pixel_value = pixel_q;
	assign range_error = err_out_q;

endmodule

// ----- rtl/core/bilinear_image_resize.sv -----
// ----------------------------------------------------------------------------
// bilinear_image_resize
// Bilinear image scaler over a planar 8-bit source store, Q8.8 results.
// ----------------------------------------------------------------------------
// A load item writes one sample into the source store in the cycle of its
// transfer and the block is ready again in the next cycle. After a request
// item's transfer the block forms the neighbor indexes and fractions, reads
// the four neighbors from the single-port source store (one neighbor per
// cycle), forms the second horizontal blend and then the vertical blend into
// the output register before it takes the next item; a request outside the
// destination skips the reads. The vertical step waits while an earlier
// result has not been transferred. The source store holds
// CHANNELS*MAX_HEIGHT*MAX_WIDTH samples, height and width each padded to a
// power of two, and is not cleared; read only samples that were loaded.

`include "bilinear_image_resize_defines.svh"

module bilinear_image_resize import bir_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int CHANNELS   = DEF_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_data,
	// items in
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [SAMPLE_W-1:0]  sample_value,
	input  logic [POS_W-1:0]     pos_x,
	input  logic [POS_W-1:0]     pos_y,
	input  logic [CH_W-1:0]      channel_index,
	// results out
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     pixel_value,
	output logic                 range_error
);

	bir_cmd_t    cmd;
	bir_status_t status;

	// sequencer
	bir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath and sample store
	bir_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.CHANNELS  (CHANNELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.sample_value (sample_value),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.channel_index(channel_index),
		.cmd          (cmd),
		.status       (status),
		.pixel_value  (pixel_value),
		.range_error  (range_error)
	);

	// a flagged result always carries a zero value
	`BIR_ASSERT_NOW(a_err_value_zero, out_valid && range_error, pixel_value == '0)

	// a request transfer occupies the block in the next cycle
	`BIR_ASSERT_NEXT(a_req_busy, in_valid && !in_stall && kind == KIND_REQUEST, in_stall)

	// a load never produces a result
	`BIR_ASSERT_NEXT(a_load_silent, in_valid && !in_stall && kind == KIND_LOAD && !out_valid, !out_valid)

endmodule
